// ===== rtl/config_text_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the configuration text tokenizer
// Each check is compiled in simulation and left out of synthesis.
// ----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define CTT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CTT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/ctt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, codes and character helpers of the configuration text
// tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

   // Widths of the fixed transaction fields.
   localparam int TEXT_W              = 8;
   localparam int FIELD_W             = 16;
   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int MAX_RESULTS         = 3;
   localparam int RES_IDX_W           = 2;

   // Token kinds.
   typedef enum logic [4:0] {
      KIND_END      = 5'd0,
      KIND_BLANK    = 5'd1,
      KIND_LPAREN   = 5'd2,
      KIND_RPAREN   = 5'd3,
      KIND_DOT      = 5'd4,
      KIND_COMMA    = 5'd5,
      KIND_EQUALS   = 5'd6,
      KIND_COLON    = 5'd7,
      KIND_LBRACKET = 5'd8,
      KIND_RBRACKET = 5'd9,
      KIND_LINE_CMT = 5'd10,
      KIND_BLOCK_CMT = 5'd11,
      KIND_STRING   = 5'd12,
      KIND_NAME     = 5'd13,
      KIND_NUMBER   = 5'd14,
      KIND_IDENT    = 5'd15,
      KIND_ERROR    = 5'd16
   } kind_type;

   // Error codes.
   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_MINUS_NO_DIGIT = 4'd1,
      ERR_DOT_NO_DIGIT  = 4'd2,
      ERR_SLASH_NO_STAR = 4'd3,
      ERR_OPEN_COMMENT  = 4'd4,
      ERR_OPEN_STRING   = 4'd5,
      ERR_NL_IN_STRING  = 4'd6,
      ERR_OPEN_NAME     = 4'd7,
      ERR_NL_IN_NAME    = 4'd8,
      ERR_UNKNOWN_CHAR  = 4'd9,
      ERR_TOO_LONG      = 4'd10
   } err_type;

   // Lexer modes.
   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_BLANK  = 4'd1,
      MODE_LCMT   = 4'd2,
      MODE_SLASH  = 4'd3,
      MODE_BCMT   = 4'd4,
      MODE_BSTAR  = 4'd5,
      MODE_STR    = 4'd6,
      MODE_NAME   = 4'd7,
      MODE_MINUS  = 4'd8,
      MODE_INT    = 4'd9,
      MODE_DOT    = 4'd10,
      MODE_FRAC   = 4'd11,
      MODE_IDENT  = 4'd12
   } mode_type;

   // Control state handed between the lexer core and the top level.
   typedef struct packed {
      mode_type mode;
      logic     halted;
   } lex_ctl_type;

   // One result transaction.
   typedef struct packed {
      kind_type             token_kind;
      logic [FIELD_W-1:0]   token_start;
      logic [FIELD_W-1:0]   token_length;
      logic [FIELD_W-1:0]   line_number;
      err_type              error_code;
      logic                 last_of_run;
   } rsp_type;

   // Character codes.
   localparam logic [TEXT_W-1:0] CH_LF     = 8'h0A;
   localparam logic [TEXT_W-1:0] CH_CR     = 8'h0D;
   localparam logic [TEXT_W-1:0] CH_TAB    = 8'h09;
   localparam logic [TEXT_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [TEXT_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [TEXT_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [TEXT_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [TEXT_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [TEXT_W-1:0] CH_EQUALS = 8'h3D;
   localparam logic [TEXT_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [TEXT_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [TEXT_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [TEXT_W-1:0] CH_HASH   = 8'h23;
   localparam logic [TEXT_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [TEXT_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [TEXT_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [TEXT_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [TEXT_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [TEXT_W-1:0] CH_UNDER  = 8'h5F;

   function automatic logic is_digit(input logic [TEXT_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [TEXT_W-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(input logic [TEXT_W-1:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

endpackage

// ===== rtl/ctt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_req_if
// Text byte channel: valid/ready handshake carrying one character.
// ----------------------------------------------------------------------------
interface ctt_req_if import ctt_pkg::*;;
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_byte;
   logic              final_byte;

   modport source (output valid, text_byte, final_byte, input ready);
   modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

// ===== rtl/ctt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_rsp_if
// Token channel: valid/ready handshake carrying one token.
// ----------------------------------------------------------------------------
interface ctt_rsp_if import ctt_pkg::*;;
   logic               valid;
   logic               ready;
   kind_type           token_kind;
   logic [FIELD_W-1:0] token_start;
   logic [FIELD_W-1:0] token_length;
   logic [FIELD_W-1:0] line_number;
   err_type            error_code;
   logic               last_of_run;

   modport source (output valid, token_kind, token_start, token_length, line_number,
                   error_code, last_of_run, input ready);
   modport sink   (input valid, token_kind, token_start, token_length, line_number,
                   error_code, last_of_run, output ready);
endinterface

// ===== rtl/ctt_lex_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_lex_core
// Combinational lexer step: from the current mode, offsets and one byte it
// works out the next state and up to three tokens.
// ----------------------------------------------------------------------------
module ctt_lex_core import ctt_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  lex_ctl_type             ctl_i,
   input  logic [OFFSET_BITS-1:0]  begin_i,
   input  logic [OFFSET_BITS-1:0]  offset_i,
   input  logic [OFFSET_BITS-1:0]  line_i,
   input  logic [TEXT_W-1:0]       byte_i,
   input  logic                    final_i,
   output lex_ctl_type             ctl_o,
   output logic [OFFSET_BITS-1:0]  begin_o,
   output logic [OFFSET_BITS-1:0]  offset_o,
   output logic [OFFSET_BITS-1:0]  line_o,
   output rsp_type                 res_o [MAX_RESULTS],
   output logic [RES_IDX_W-1:0]    count_o
);

   localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
   localparam logic [OFFSET_BITS-1:0] OFS_ONE = OFFSET_BITS'(1);
   localparam logic [RES_IDX_W-1:0]   RES_ONE = RES_IDX_W'(1);

   // Builds one token from offset-width values.
   function automatic rsp_type mk_rsp(input kind_type k,
                                      input logic [OFFSET_BITS-1:0] s,
                                      input logic [OFFSET_BITS-1:0] l,
                                      input logic [OFFSET_BITS-1:0] ln,
                                      input err_type e);
      rsp_type r;
      r.token_kind   = k;
      r.token_start  = FIELD_W'(s);
      r.token_length = FIELD_W'(l);
      r.line_number  = FIELD_W'(ln);
      r.error_code   = e;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // One pass over the byte, in the order the tokens are produced.
   always_comb begin
      mode_type               mode;
      logic                   halt;
      logic                   restart;
      logic [OFFSET_BITS-1:0] tb;
      logic [OFFSET_BITS-1:0] lc;
      logic [OFFSET_BITS-1:0] ofs;
      logic [OFFSET_BITS-1:0] pos;
      logic [OFFSET_BITS-1:0] upto;
      logic [OFFSET_BITS-1:0] flen;
      logic [RES_IDX_W-1:0]   n;
      logic [TEXT_W-1:0]      c;
      rsp_type                res [MAX_RESULTS];

      mode    = ctl_i.mode;
      halt    = ctl_i.halted;
      restart = 1'b0;
      tb      = begin_i;
      lc      = line_i;
      ofs     = offset_i;
      pos     = offset_i;
      upto    = offset_i + OFS_ONE - begin_i;
      flen    = '0;
      n       = '0;
      c       = byte_i;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      if (!halt) begin
         if (offset_i == OFS_MAX) begin
            // Text longer than the offset counter can hold.
            tb = offset_i;
            res[n] = mk_rsp(KIND_ERROR, tb, '0, lc, ERR_TOO_LONG);
            n = n + RES_ONE;
            halt = 1'b1;
            mode = MODE_IDLE;
         end else begin
            // Continue the pending token, or close it and restart on this byte.
            unique case (mode)
               MODE_BLANK: begin
                  if (c == CH_LF) begin
                     lc = lc + OFS_ONE;
                  end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
                     res[n] = mk_rsp(KIND_BLANK, tb, pos - tb, lc, ERR_NONE);
                     n = n + RES_ONE;
                     restart = 1'b1;
                  end
               end
               MODE_LCMT: begin
                  if (c == CH_LF || c == CH_CR) begin
                     res[n] = mk_rsp(KIND_LINE_CMT, tb, pos - tb, lc, ERR_NONE);
                     n = n + RES_ONE;
                     restart = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (c == CH_STAR) begin
                     mode = MODE_BCMT;
                  end else begin
                     res[n] = mk_rsp(KIND_ERROR, tb, upto, lc, ERR_SLASH_NO_STAR);
                     n = n + RES_ONE;
                     halt = 1'b1;
                     mode = MODE_IDLE;
                  end
               end
               MODE_BCMT, MODE_BSTAR: begin
                  if (mode == MODE_BSTAR && c == CH_SLASH) begin
                     res[n] = mk_rsp(KIND_BLOCK_CMT, tb, upto, lc, ERR_NONE);
                     n = n + RES_ONE;
                     mode = MODE_IDLE;
                  end else if (c == CH_STAR) begin
                     mode = MODE_BSTAR;
                  end else begin
                     if (c == CH_LF) begin
                        lc = lc + OFS_ONE;
                     end
                     mode = MODE_BCMT;
                  end
               end
               MODE_STR, MODE_NAME: begin
                  if ((mode == MODE_STR && c == CH_DQUOTE) ||
                      (mode == MODE_NAME && c == CH_SQUOTE)) begin
                     res[n] = mk_rsp((mode == MODE_STR) ? KIND_STRING : KIND_NAME,
                                     tb, upto, lc, ERR_NONE);
                     n = n + RES_ONE;
                     mode = MODE_IDLE;
                  end else if (c == CH_LF || c == CH_CR) begin
                     res[n] = mk_rsp(KIND_ERROR, tb, upto, lc,
                                     (mode == MODE_STR) ? ERR_NL_IN_STRING : ERR_NL_IN_NAME);
                     n = n + RES_ONE;
                     halt = 1'b1;
                     mode = MODE_IDLE;
                  end
               end
               MODE_MINUS: begin
                  if (is_digit(c)) begin
                     mode = MODE_INT;
                  end else begin
                     res[n] = mk_rsp(KIND_ERROR, tb, upto, lc, ERR_MINUS_NO_DIGIT);
                     n = n + RES_ONE;
                     halt = 1'b1;
                     mode = MODE_IDLE;
                  end
               end
               MODE_INT: begin
                  if (c == CH_DOT) begin
                     mode = MODE_DOT;
                  end else if (!is_digit(c)) begin
                     res[n] = mk_rsp(KIND_NUMBER, tb, pos - tb, lc, ERR_NONE);
                     n = n + RES_ONE;
                     restart = 1'b1;
                  end
               end
               MODE_DOT: begin
                  if (is_digit(c)) begin
                     mode = MODE_FRAC;
                  end else begin
                     res[n] = mk_rsp(KIND_ERROR, tb, upto, lc, ERR_DOT_NO_DIGIT);
                     n = n + RES_ONE;
                     halt = 1'b1;
                     mode = MODE_IDLE;
                  end
               end
               MODE_FRAC: begin
                  if (!is_digit(c)) begin
                     res[n] = mk_rsp(KIND_NUMBER, tb, pos - tb, lc, ERR_NONE);
                     n = n + RES_ONE;
                     restart = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (!is_word(c)) begin
                     res[n] = mk_rsp(KIND_IDENT, tb, pos - tb, lc, ERR_NONE);
                     n = n + RES_ONE;
                     restart = 1'b1;
                  end
               end
               default: begin
                  restart = 1'b1;
               end
            endcase

            // Start of a new token at this byte.
            if (restart) begin
               tb   = pos;
               mode = MODE_IDLE;
               unique case (c)
                  CH_LF: begin
                     lc   = lc + OFS_ONE;
                     mode = MODE_BLANK;
                  end
                  CH_CR, CH_TAB, CH_SPACE: begin
                     mode = MODE_IDLE;
                  end
                  CH_LPAREN: begin
                     res[n] = mk_rsp(KIND_LPAREN, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_RPAREN: begin
                     res[n] = mk_rsp(KIND_RPAREN, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_DOT: begin
                     res[n] = mk_rsp(KIND_DOT, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_COMMA: begin
                     res[n] = mk_rsp(KIND_COMMA, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_EQUALS: begin
                     res[n] = mk_rsp(KIND_EQUALS, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_COLON: begin
                     res[n] = mk_rsp(KIND_COLON, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_LBRACK: begin
                     res[n] = mk_rsp(KIND_LBRACKET, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_RBRACK: begin
                     res[n] = mk_rsp(KIND_RBRACKET, pos, OFS_ONE, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  CH_HASH:   mode = MODE_LCMT;
                  CH_SLASH:  mode = MODE_SLASH;
                  CH_DQUOTE: mode = MODE_STR;
                  CH_SQUOTE: mode = MODE_NAME;
                  CH_MINUS:  mode = MODE_MINUS;
                  default: begin
                     if (is_digit(c)) begin
                        mode = MODE_INT;
                     end else if (is_alpha(c) || c == CH_UNDER) begin
                        mode = MODE_IDENT;
                     end else begin
                        res[n] = mk_rsp(KIND_ERROR, tb, OFS_ONE, lc, ERR_UNKNOWN_CHAR);
                        n = n + RES_ONE;
                        halt = 1'b1;
                     end
                  end
               endcase
            end

            ofs = pos + OFS_ONE;

            // On the last byte, close whatever token is still open.
            if (final_i && !halt) begin
               flen = ofs - tb;
               unique case (mode)
                  MODE_BLANK: begin
                     res[n] = mk_rsp(KIND_BLANK, tb, flen, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  MODE_LCMT: begin
                     res[n] = mk_rsp(KIND_LINE_CMT, tb, flen, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  MODE_INT, MODE_FRAC: begin
                     res[n] = mk_rsp(KIND_NUMBER, tb, flen, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  MODE_IDENT: begin
                     res[n] = mk_rsp(KIND_IDENT, tb, flen, lc, ERR_NONE);
                     n = n + RES_ONE;
                  end
                  MODE_MINUS: begin
                     res[n] = mk_rsp(KIND_ERROR, tb, flen, lc, ERR_MINUS_NO_DIGIT);
                     n = n + RES_ONE;
                  end
                  MODE_DOT: begin
                     res[n] = mk_rsp(KIND_ERROR, tb, flen, lc, ERR_DOT_NO_DIGIT);
                     n = n + RES_ONE;
                  end
                  MODE_SLASH: begin
                     res[n] = mk_rsp(KIND_ERROR, tb, flen, lc, ERR_SLASH_NO_STAR);
                     n = n + RES_ONE;
                  end
                  MODE_BCMT, MODE_BSTAR: begin
                     res[n] = mk_rsp(KIND_ERROR, tb, flen, lc, ERR_OPEN_COMMENT);
                     n = n + RES_ONE;
                  end
                  MODE_STR: begin
                     res[n] = mk_rsp(KIND_ERROR, tb, flen, lc, ERR_OPEN_STRING);
                     n = n + RES_ONE;
                  end
                  MODE_NAME: begin
                     res[n] = mk_rsp(KIND_ERROR, tb, flen, lc, ERR_OPEN_NAME);
                     n = n + RES_ONE;
                  end
                  default: begin
                     mode = MODE_IDLE;
                  end
               endcase
               mode = MODE_IDLE;
            end
         end
      end

      // The last byte ends the text with an end token and a full reset.
      if (final_i) begin
         res[n] = mk_rsp(KIND_END, '0, '0, lc, ERR_NONE);
         n    = n + RES_ONE;
         mode = MODE_IDLE;
         halt = 1'b0;
         tb   = '0;
         ofs  = '0;
         lc   = '0;
      end

      if (n != '0) begin
         res[n - RES_ONE].last_of_run = 1'b1;
      end

      ctl_o.mode   = mode;
      ctl_o.halted = halt;
      begin_o      = tb;
      offset_o     = ofs;
      line_o       = lc;
      res_o        = res;
      count_o      = n;
   end

endmodule

// ===== rtl/config_text_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_top
// Streaming tokenizer for configuration text, one byte per transaction.
//
// Usage:
//   req_chan carries text_byte and final_byte; final_byte marks the last byte
//   of a text, which flushes any open token and adds an end token.
//   rsp_chan carries one token per transaction; last_of_run is set on the
//   last token caused by a byte. A byte may cause zero to three tokens.
// Flow: an accepted byte waits in the input register, is lexed from there,
//   and its tokens are written into the token register, which offers them.
// Throughput: one byte per cycle while each byte causes at most one token
//   and rsp_chan is not held. A byte that causes several tokens holds the
//   lexer until the token register has drained them one by one.
// Stalls: while rsp_chan is held, the token register keeps its tokens and
//   one further byte waits in the input register; then req_chan.ready drops.
// Reset: synchronous, active high; it clears the lexer state, the offset and
//   line counters and all pending transactions.
// ----------------------------------------------------------------------------
module config_text_tokenizer_top import ctt_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   ctt_req_if.sink      req_chan,
   ctt_rsp_if.source    rsp_chan
);

`include "config_text_tokenizer_top_macros.svh"

   localparam logic [RES_IDX_W-1:0] RES_ONE = RES_IDX_W'(1);

   // Input register.
   logic                   in_valid_ff, in_valid_in;
   logic [TEXT_W-1:0]      in_byte_ff,  in_byte_in;
   logic                   in_final_ff, in_final_in;

   // Lexer state.
   lex_ctl_type            ctl_ff,    ctl_in;
   logic [OFFSET_BITS-1:0] begin_ff,  begin_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] line_ff,   line_in;

   // Token register: the tokens of one byte, drained one per cycle while rsp_chan is ready.
   rsp_type                slot_ff [MAX_RESULTS];
   rsp_type                slot_in [MAX_RESULTS];
   logic [RES_IDX_W-1:0]   count_ff, count_in;
   logic [RES_IDX_W-1:0]   idx_ff,   idx_in;

   // Lexer outputs.
   lex_ctl_type            lex_ctl;
   logic [OFFSET_BITS-1:0] lex_begin;
   logic [OFFSET_BITS-1:0] lex_offset;
   logic [OFFSET_BITS-1:0] lex_line;
   rsp_type                lex_res [MAX_RESULTS];
   logic [RES_IDX_W-1:0]   lex_count;

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   rsp_last;
   logic                   advance;

   ctt_lex_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_lex_core (
      .ctl_i    (ctl_ff),
      .begin_i  (begin_ff),
      .offset_i (offset_ff),
      .line_i   (line_ff),
      .byte_i   (in_byte_ff),
      .final_i  (in_final_ff),
      .ctl_o    (lex_ctl),
      .begin_o  (lex_begin),
      .offset_o (lex_offset),
      .line_o   (lex_line),
      .res_o    (lex_res),
      .count_o  (lex_count)
   );

   // Handshake control: the lexer advances once the token register is free
   // or gives up its last token in this cycle.
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign rsp_last       = (idx_ff == count_ff - RES_ONE);
   assign advance        = in_valid_ff && ((count_ff == '0) || (rsp_fire && rsp_last));
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Result channel outputs.
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.token_kind   = slot_ff[idx_ff].token_kind;
   assign rsp_chan.token_start  = slot_ff[idx_ff].token_start;
   assign rsp_chan.token_length = slot_ff[idx_ff].token_length;
   assign rsp_chan.line_number  = slot_ff[idx_ff].line_number;
   assign rsp_chan.error_code   = slot_ff[idx_ff].error_code;
   assign rsp_chan.last_of_run  = slot_ff[idx_ff].last_of_run;

   // Next values of the input register, state and token register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      ctl_in      = ctl_ff;
      begin_in    = begin_ff;
      offset_in   = offset_ff;
      line_in     = line_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.text_byte;
         in_final_in = req_chan.final_byte;
      end

      if (rsp_fire) begin
         if (rsp_last) begin
            count_in = '0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + RES_ONE;
         end
      end

      if (advance) begin
         ctl_in    = lex_ctl;
         begin_in  = lex_begin;
         offset_in = lex_offset;
         line_in   = lex_line;
         slot_in   = lex_res;
         count_in  = lex_count;
         idx_in    = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ctl_ff      <= '{mode: MODE_IDLE, halted: 1'b0};
         begin_ff    <= '0;
         offset_ff   <= '0;
         line_ff     <= '0;
         count_ff    <= '0;
         idx_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         ctl_ff      <= ctl_in;
         begin_ff    <= begin_in;
         offset_ff   <= offset_in;
         line_ff     <= line_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      slot_ff     <= slot_in;
   end

   // Checks on the token register and the end-of-text reset.
   `CTT_ASSERT_IMP(a_idx_in_range, clock, reset, count_ff != '0, idx_ff < count_ff, "token index beyond token count")
   `CTT_ASSERT_IMP(a_last_flag, clock, reset, rsp_chan.valid && rsp_last, rsp_chan.last_of_run, "last token of a byte lacks last_of_run")
   `CTT_ASSERT_NEXT(a_final_clears, clock, reset, advance && in_final_ff, (offset_ff == '0) && (line_ff == '0) && !ctl_ff.halted, "state not cleared after last byte")

endmodule
